// File: rtl/layer_stack_manager_defines.svh
// assertion macros shared by the checker
`ifndef LAYER_STACK_MANAGER_DEFINES_SVH
`define LAYER_STACK_MANAGER_DEFINES_SVH

// same-cycle implication
`define LSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lsm_pkg.sv
package lsm_pkg;

  // wide signed screen coordinate, room for a 16-bit sum
  typedef logic signed [17:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } rect_t;

  typedef struct packed {
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
  } srect_t;

  // per-layer geometry word
  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [11:0]        w;
    logic [11:0]        r;
  } geo_t;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_NO_FREE = 1'b1;

  function automatic coord_t ext_s(input logic signed [15:0] v);
    return coord_t'(v);
  endfunction

  function automatic coord_t ext_u(input logic [11:0] v);
    return coord_t'({1'b0, v});
  endfunction

  function automatic logic signed [15:0] sat16(input coord_t v);
    logic signed [15:0] res;
    if (v < -coord_t'(32768)) res = 16'sh8000;
    else if (v > coord_t'(32767)) res = 16'sh7fff;
    else res = v[15:0];
    return res;
  endfunction

endpackage

// File: rtl/lsm_clip.sv
module lsm_clip (
  input  lsm_pkg::rect_t  rect,
  input  logic [11:0]     screen_w,
  input  logic [11:0]     screen_h,
  output lsm_pkg::srect_t clipped
);

  lsm_pkg::coord_t sw;
  lsm_pkg::coord_t sh;
  lsm_pkg::coord_t x0c;
  lsm_pkg::coord_t y0c;
  lsm_pkg::coord_t x1c;
  lsm_pkg::coord_t y1c;

  // clip to the screen, then saturate to 16 bits
  always_comb begin
    sw  = lsm_pkg::ext_u(screen_w);
    sh  = lsm_pkg::ext_u(screen_h);
    x0c = (rect.x0 < 0) ? '0 : rect.x0;
    y0c = (rect.y0 < 0) ? '0 : rect.y0;
    x1c = (rect.x1 > sw) ? sw : rect.x1;
    y1c = (rect.y1 > sh) ? sh : rect.y1;
    clipped.x0 = lsm_pkg::sat16(x0c);
    clipped.y0 = lsm_pkg::sat16(y0c);
    clipped.x1 = lsm_pkg::sat16(x1c);
    clipped.y1 = lsm_pkg::sat16(y1c);
  end

endmodule

// File: rtl/layer_stack_manager.sv
// Layer stack manager: keeps the layer table and bottom-to-top order table.
// Input channel (in_valid/in_ready) carries one command: allocate, free,
// set buffer, set level, move or refresh. Output channel (out_valid/
// out_ready) returns one or two results per command, the final one with
// last set; move of a visible layer gives two, everything else one.
// Screen size is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, the block itself does not enforce this.
// Allocate scans the in-use bits one layer per cycle. A level change shifts
// the order table one entry per cycle through its single read and write
// port. One command is worked on at a time; in_ready is high only while
// the sequencer is idle, and the next command is taken while the last
// result still waits in the output register.
// If the receiver stalls, the output register holds its result and the
// sequencer waits before loading another one.
// Reset clears the in-use bits, sets the top level to minus one (nothing
// shown) and the screen to 320 by 200; the other tables are undefined
// until written.
module layer_stack_manager #(
  parameter int LAYERS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [7:0]         layer,
  input  logic [31:0]        buffer_base,
  input  logic [11:0]        buffer_width,
  input  logic [11:0]        buffer_rows,
  input  logic signed [8:0]  key_colour,
  input  logic signed [9:0]  wanted_level,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic [7:0]         given_layer,
  output logic               region_valid,
  output logic signed [15:0] rect_x0,
  output logic signed [15:0] rect_y0,
  output logic signed [15:0] rect_x1,
  output logic signed [15:0] rect_y1,
  output logic [8:0]         from_level,
  output logic               last
);

  localparam int LW  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int LVW = LW + 1;
  localparam int CW  = ((LVW > 10) ? LVW : 10) + 2;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_FREE  = 3'd1;
  localparam logic [2:0] KIND_SETBUF = 3'd2;
  localparam logic [2:0] KIND_LEVEL = 3'd3;
  localparam logic [2:0] KIND_MOVE  = 3'd4;
  localparam logic [2:0] KIND_REFRESH = 3'd5;

  localparam logic REG_SCREEN_W = 1'b0;
  localparam logic REG_SCREEN_H = 1'b1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ALLOC = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_SHRD  = 4'd4;
  localparam logic [3:0] S_SH    = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_EMIT1 = 4'd7;
  localparam logic [3:0] S_EMIT2 = 4'd8;
  localparam logic [3:0] S_NULL  = 4'd9;

  logic [3:0] state;
  logic [11:0] screen_w;
  logic [11:0] screen_h;

  // latched command
  logic [2:0]         kind_q;
  logic [7:0]         layer_q;
  logic [31:0]        base_q;
  logic [11:0]        bw_q;
  logic [11:0]        br_q;
  logic signed [8:0]  key_q;
  logic signed [9:0]  want_q;
  logic signed [15:0] px_q;
  logic signed [15:0] py_q;
  logic signed [15:0] ex_q;
  logic signed [15:0] ey_q;

  // tables
  logic [LAYERS-1:0]    in_use;
  logic signed [LVW-1:0] top_lvl;
  logic [LW-1:0]        ord_mem [LAYERS];
  logic signed [LVW-1:0] lvl_mem [LAYERS];
  lsm_pkg::geo_t        geo_mem [LAYERS];
  logic [40:0]          buf_mem [LAYERS];
  logic [LW-1:0]        ord_rd;
  logic signed [LVW-1:0] lvl_rd;
  lsm_pkg::geo_t        geo_rd;

  // sequencer working registers
  logic [LW-1:0]         scan;
  logic                  up_q;
  logic signed [LVW-1:0] wdst;
  logic signed [LVW-1:0] wend;
  logic signed [LVW-1:0] h_q;
  logic [8:0]            from_q;
  logic [8:0]            old_from_q;
  logic                  inc_q;
  logic                  dec_q;
  logic                  free_q;
  logic                  two_q;
  logic                  st_q;
  logic [7:0]            given_q;
  lsm_pkg::geo_t         g_q;
  lsm_pkg::rect_t        r_q;

  logic                  in_fire;
  logic                  ok_out;
  logic [LW-1:0]         lay_idx;
  logic                  bad;

  // decode terms
  logic signed [CW-1:0] old_c;
  logic signed [CW-1:0] top_c;
  logic signed [CW-1:0] want_c;
  logic signed [CW-1:0] maxh;
  logic signed [CW-1:0] h_c;
  logic signed [CW-1:0] from_c;
  logic signed [CW-1:0] src_c;
  logic [8:0]           from9;
  lsm_pkg::rect_t       lay_rect;
  lsm_pkg::rect_t       clip_in;
  lsm_pkg::srect_t      clip_out;

  // memory port controls
  logic                  ord_we;
  logic [LW-1:0]         ord_waddr;
  logic [LW-1:0]         ord_wdata;
  logic [LW-1:0]         ord_raddr;
  logic                  lvl_we;
  logic [LW-1:0]         lvl_waddr;
  logic signed [LVW-1:0] lvl_wdata;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign ok_out   = !out_valid || out_ready;
  assign lay_idx  = LW'(layer_q);
  assign bad      = (kind_q > KIND_REFRESH) || (32'(layer_q) >= 32'(LAYERS))
                    || !in_use[lay_idx];

  // level clamp and repaint start level
  always_comb begin
    old_c  = CW'(lvl_rd);
    top_c  = CW'(top_lvl);
    want_c = (kind_q == KIND_FREE) ? -CW'(1) : CW'(want_q);
    maxh   = (old_c >= 0) ? top_c : top_c + CW'(1);
    h_c    = (want_c > maxh) ? maxh : want_c;
    if (h_c < -CW'(1)) h_c = -CW'(1);
    if (old_c > h_c) from_c = (h_c >= 0) ? h_c + CW'(1) : '0;
    else from_c = h_c;
    from9 = (from_c > CW'(511)) ? 9'd511 : from_c[8:0];
    lay_rect.x0 = lsm_pkg::ext_s(geo_rd.px);
    lay_rect.y0 = lsm_pkg::ext_s(geo_rd.py);
    lay_rect.x1 = lsm_pkg::ext_s(geo_rd.px) + lsm_pkg::ext_u(geo_rd.w);
    lay_rect.y1 = lsm_pkg::ext_s(geo_rd.py) + lsm_pkg::ext_u(geo_rd.r);
  end

  // order table source index during a shift
  always_comb begin
    if (state == S_SHRD) begin
      src_c = up_q ? CW'(wdst) + CW'(1) : CW'(wdst) - CW'(1);
    end else begin
      src_c = up_q ? CW'(wdst) + CW'(2) : CW'(wdst) - CW'(2);
    end
    ord_raddr = src_c[LW-1:0];
  end

  // memory write selection
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = wdst[LW-1:0];
    ord_wdata = ord_rd;
    lvl_we    = 1'b0;
    lvl_waddr = ord_rd;
    lvl_wdata = wdst;
    case (state)
      S_ALLOC: begin
        lvl_we    = !in_use[scan];
        lvl_waddr = scan;
        lvl_wdata = -LVW'(1);
      end
      S_SH: begin
        ord_we = 1'b1;
        lvl_we = 1'b1;
      end
      S_FIN: begin
        ord_we    = (h_q >= 0);
        ord_waddr = h_q[LW-1:0];
        ord_wdata = lay_idx;
        lvl_we    = 1'b1;
        lvl_waddr = lay_idx;
        lvl_wdata = h_q;
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_rd <= ord_mem[ord_raddr];
    if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
    lvl_rd <= lvl_mem[lay_idx];
    if (state == S_DEC && !bad && kind_q == KIND_SETBUF) begin
      geo_mem[lay_idx] <= '{px: geo_rd.px, py: geo_rd.py, w: bw_q, r: br_q};
      buf_mem[lay_idx] <= {base_q, key_q};
    end else if (state == S_DEC && !bad && kind_q == KIND_MOVE) begin
      geo_mem[lay_idx] <= '{px: px_q, py: py_q, w: geo_rd.w, r: geo_rd.r};
    end
    geo_rd <= geo_mem[lay_idx];
  end

  // shared clip unit
  always_comb begin
    if (state == S_EMIT2) begin
      clip_in.x0 = lsm_pkg::ext_s(px_q);
      clip_in.y0 = lsm_pkg::ext_s(py_q);
      clip_in.x1 = lsm_pkg::ext_s(px_q) + lsm_pkg::ext_u(g_q.w);
      clip_in.y1 = lsm_pkg::ext_s(py_q) + lsm_pkg::ext_u(g_q.r);
    end else begin
      clip_in = r_q;
    end
  end

  lsm_clip u_clip (
    .rect     (clip_in),
    .screen_w (screen_w),
    .screen_h (screen_h),
    .clipped  (clip_out)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w <= 12'd320;
      screen_h <= 12'd200;
    end else if (cfg_write) begin
      if (cfg_index == REG_SCREEN_W) screen_w <= cfg_data;
      if (cfg_index == REG_SCREEN_H) screen_h <= cfg_data;
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q  <= kind;
      layer_q <= layer;
      base_q  <= buffer_base;
      bw_q    <= buffer_width;
      br_q    <= buffer_rows;
      key_q   <= key_colour;
      want_q  <= wanted_level;
      px_q    <= pos_x;
      py_q    <= pos_y;
      ex_q    <= end_x;
      ey_q    <= end_y;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_use  <= '0;
      top_lvl <= -LVW'(1);
      scan    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            scan    <= '0;
            st_q    <= lsm_pkg::STATUS_DONE;
            given_q <= '0;
            state   <= (kind == KIND_ALLOC) ? S_ALLOC : S_RD;
          end
        end
        S_ALLOC: begin
          if (!in_use[scan]) begin
            in_use[scan] <= 1'b1;
            given_q      <= 8'(scan);
            state        <= S_NULL;
          end else if (32'(scan) == 32'(LAYERS - 1)) begin
            st_q  <= lsm_pkg::STATUS_NO_FREE;
            state <= S_NULL;
          end else begin
            scan <= scan + LW'(1);
          end
        end
        S_RD: begin
          state <= S_DEC;
        end
        S_DEC: begin
          g_q        <= geo_rd;
          h_q        <= h_c[LVW-1:0];
          from_q     <= from9;
          old_from_q <= lvl_rd[8:0];
          r_q        <= lay_rect;
          two_q      <= 1'b0;
          free_q     <= (kind_q == KIND_FREE);
          inc_q      <= 1'b0;
          dec_q      <= 1'b0;
          state      <= S_NULL;
          if (!bad) begin
            case (kind_q)
              KIND_FREE, KIND_LEVEL: begin
                if (kind_q == KIND_FREE && old_c < 0) begin
                  in_use[lay_idx] <= 1'b0;
                end else if (old_c > h_c && h_c >= 0) begin
                  // lowering: shift entries up from old down to h+1
                  up_q  <= 1'b0;
                  wdst  <= lvl_rd;
                  wend  <= LVW'(h_c + CW'(1));
                  state <= S_SHRD;
                end else if (old_c > h_c) begin
                  // hiding: close the gap above old
                  up_q  <= 1'b1;
                  wdst  <= lvl_rd;
                  wend  <= top_lvl - LVW'(1);
                  dec_q <= 1'b1;
                  state <= (old_c == top_c) ? S_FIN : S_SHRD;
                end else if (old_c < h_c && old_c >= 0) begin
                  // raising
                  up_q  <= 1'b1;
                  wdst  <= lvl_rd;
                  wend  <= LVW'(h_c - CW'(1));
                  state <= S_SHRD;
                end else if (old_c < h_c) begin
                  // showing: open a gap at h
                  up_q  <= 1'b0;
                  wdst  <= top_lvl + LVW'(1);
                  wend  <= LVW'(h_c + CW'(1));
                  inc_q <= 1'b1;
                  state <= (top_c + CW'(1) == h_c) ? S_FIN : S_SHRD;
                end
              end
              KIND_MOVE: begin
                if (old_c >= 0) begin
                  from_q <= '0;
                  two_q  <= 1'b1;
                  state  <= S_EMIT1;
                end
              end
              KIND_REFRESH: begin
                if (old_c >= 0) begin
                  r_q.x0 <= lsm_pkg::ext_s(geo_rd.px) + lsm_pkg::ext_s(px_q);
                  r_q.y0 <= lsm_pkg::ext_s(geo_rd.py) + lsm_pkg::ext_s(py_q);
                  r_q.x1 <= lsm_pkg::ext_s(geo_rd.px) + lsm_pkg::ext_s(ex_q);
                  r_q.y1 <= lsm_pkg::ext_s(geo_rd.py) + lsm_pkg::ext_s(ey_q);
                  from_q <= lvl_rd[8:0];
                  state  <= S_EMIT1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SHRD: begin
          state <= S_SH;
        end
        S_SH: begin
          if (wdst == wend) begin
            state <= S_FIN;
          end else begin
            wdst <= up_q ? wdst + LVW'(1) : wdst - LVW'(1);
          end
        end
        S_FIN: begin
          if (inc_q) top_lvl <= top_lvl + LVW'(1);
          if (dec_q) top_lvl <= top_lvl - LVW'(1);
          if (free_q) in_use[lay_idx] <= 1'b0;
          state <= S_EMIT1;
        end
        S_EMIT1: begin
          if (ok_out) state <= two_q ? S_EMIT2 : S_IDLE;
        end
        S_EMIT2, S_NULL: begin
          if (ok_out) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ok_out && (state == S_EMIT1 || state == S_EMIT2 || state == S_NULL)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ok_out) begin
      case (state)
        S_EMIT1, S_EMIT2: begin
          status       <= lsm_pkg::STATUS_DONE;
          given_layer  <= '0;
          region_valid <= 1'b1;
          rect_x0      <= clip_out.x0;
          rect_y0      <= clip_out.y0;
          rect_x1      <= clip_out.x1;
          rect_y1      <= clip_out.y1;
          from_level   <= (state == S_EMIT2) ? old_from_q : from_q;
          last         <= (state == S_EMIT2) || !two_q;
        end
        S_NULL: begin
          status       <= st_q;
          given_layer  <= given_q;
          region_valid <= 1'b0;
          rect_x0      <= '0;
          rect_y0      <= '0;
          rect_x1      <= '0;
          rect_y1      <= '0;
          from_level   <= '0;
          last         <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/lsm_checker.sv
`include "layer_stack_manager_defines.svh"

module lsm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               status,
  input logic               region_valid,
  input logic signed [15:0] rect_x0,
  input logic signed [15:0] rect_y0,
  input logic signed [15:0] rect_x1,
  input logic signed [15:0] rect_y1,
  input logic [8:0]         from_level,
  input logic               last
);

  // one command at a time: a transfer in drops ready
  `LSM_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready after transfer")

  // a result without a rectangle carries zero edges and level
  `LSM_ASSERT_NOW(a_empty_result, out_valid && !region_valid, rect_x0 == 0 && rect_y0 == 0 && rect_x1 == 0 && rect_y1 == 0 && from_level == 0, "stray rectangle")

  // an allocation failure is a lone final result
  `LSM_ASSERT_NOW(a_no_free, out_valid && status, last && !region_valid, "bad failure result")

  // a stalled result stays put
  `LSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(last) && $stable(rect_x0), "result dropped")

endmodule

bind layer_stack_manager lsm_checker u_lsm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .region_valid (region_valid),
  .rect_x0      (rect_x0),
  .rect_y0      (rect_y0),
  .rect_x1      (rect_x1),
  .rect_y1      (rect_y1),
  .from_level   (from_level),
  .last         (last)
);
